[src/nand_command_sequencer_top_assert.svh]
// ----------------------------------------------------------------------------
// nand_command_sequencer_top_assert.svh
// Assertion macros for the NAND command sequencer; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef NAND_COMMAND_SEQUENCER_TOP_ASSERT_SVH
`define NAND_COMMAND_SEQUENCER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define NCS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ncs: property violated");
`define NCS_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("ncs: forbidden condition");
`else
`define NCS_ASSERT(label, clk, rst_n, prop)
`define NCS_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

[src/ncs_pkg.sv]
// ----------------------------------------------------------------------------
// ncs_pkg
// Shared types, codes and the bus cycle lookup of the NAND command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ncs_pkg;

	localparam int OPW   = 2;
	localparam int COLW  = 16;
	localparam int ROWW  = 24;
	localparam int KINDW = 3;
	localparam int VALW  = 8;
	localparam int STEPW = 4;

	localparam logic [OPW-1:0] OP_RESET     = 2'd0;
	localparam logic [OPW-1:0] OP_READ_ID   = 2'd1;
	localparam logic [OPW-1:0] OP_STATUS    = 2'd2;
	localparam logic [OPW-1:0] OP_READ_PAGE = 2'd3;

	localparam logic [KINDW-1:0] KIND_CMD        = 3'd0;
	localparam logic [KINDW-1:0] KIND_ADDR       = 3'd1;
	localparam logic [KINDW-1:0] KIND_PAGE_OUT   = 3'd2;
	localparam logic [KINDW-1:0] KIND_ID_OUT     = 3'd3;
	localparam logic [KINDW-1:0] KIND_STATUS_OUT = 3'd4;

	localparam logic [VALW-1:0] CMD_RESET      = 8'hFF;
	localparam logic [VALW-1:0] CMD_READ_ID    = 8'h90;
	localparam logic [VALW-1:0] CMD_STATUS     = 8'h70;
	localparam logic [VALW-1:0] CMD_READ0      = 8'h00;
	localparam logic [VALW-1:0] CMD_READ_START = 8'h30;

	// longest run is a large page read: eleven bus cycles, steps 0..10
	localparam logic [STEPW-1:0] MAX_STEP = 4'd10;

	localparam int QDEPTH = 2;
	localparam int PTRW   = $clog2(QDEPTH);
	localparam int CNTW   = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [OPW-1:0]  opcode;
		logic            large_pg;
		logic [COLW-1:0] column;
		logic [ROWW-1:0] row;
	} desc_t;

	typedef struct packed {
		logic [KINDW-1:0] kind;
		logic [VALW-1:0]  value;
		logic             last;
	} bus_cycle_t;

	// Bus cycle number 'step' of the run for one request.
	// Small page runs skip the column high byte, so their steps from two on
	// are shifted up by one onto the large page numbering.
	function automatic bus_cycle_t cycle_at(desc_t d, logic [STEPW-1:0] step);
		logic [STEPW-1:0] e;
		logic [STEPW-1:0] buf_idx;
		bus_cycle_t c;
		c.kind  = KIND_CMD;
		c.value = '0;
		c.last  = 1'b0;
		e = (!d.large_pg && (step >= 4'd2)) ? step + 4'd1 : step;
		buf_idx = e - 4'd7;
		case (d.opcode)
			OP_RESET: begin
				c.value = CMD_RESET;
				c.last  = 1'b1;
			end
			OP_READ_ID: begin
				if (step == '0) begin
					c.value = CMD_READ_ID;
				end else begin
					c.kind = KIND_ID_OUT;
					c.last = 1'b1;
				end
			end
			OP_STATUS: begin
				if (step == '0) begin
					c.value = CMD_STATUS;
				end else begin
					c.kind = KIND_STATUS_OUT;
					c.last = 1'b1;
				end
			end
			default: begin
				case (e)
					4'd0: c.value = CMD_READ0;
					4'd1: begin
						c.kind  = KIND_ADDR;
						c.value = d.column[7:0];
					end
					4'd2: begin
						c.kind  = KIND_ADDR;
						c.value = d.column[15:8];
					end
					4'd3: begin
						c.kind  = KIND_ADDR;
						c.value = d.row[7:0];
					end
					4'd4: begin
						c.kind  = KIND_ADDR;
						c.value = d.row[15:8];
					end
					4'd5: begin
						c.kind  = KIND_ADDR;
						c.value = d.row[23:16];
					end
					4'd6: begin
						if (d.large_pg) begin
							c.value = CMD_READ_START;
						end else begin
							c.kind = KIND_PAGE_OUT;
							c.last = 1'b1;
						end
					end
					default: begin
						c.kind  = KIND_PAGE_OUT;
						c.value = {{(VALW-STEPW){1'b0}}, buf_idx};
						c.last  = (e == MAX_STEP);
					end
				endcase
			end
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[src/ncs_front.sv]
// ----------------------------------------------------------------------------
// ncs_front
// Holds the page size register and turns each request into a run descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module ncs_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [ncs_pkg::OPW-1:0]  opcode,
	input  wire logic [ncs_pkg::COLW-1:0] column,
	input  wire logic [ncs_pkg::ROWW-1:0] page_row,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_wdata,
	input  wire logic                  q_full,
	output logic                       q_push,
	output ncs_pkg::desc_t             q_desc
);
	import ncs_pkg::*;

	logic large_page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			large_page_q <= 1'b0;
		end else if (cfg_we) begin
			large_page_q <= cfg_wdata;
		end
	end

	assign full   = q_full;
	assign q_push = push && !q_full;

	// address fields only matter for page reads; zero them otherwise
	always_comb begin
		q_desc.opcode   = opcode;
		q_desc.large_pg = large_page_q;
		q_desc.column   = (opcode == OP_READ_PAGE) ? column : '0;
		q_desc.row      = (opcode == OP_READ_PAGE) ? page_row : '0;
	end

endmodule

`default_nettype wire

[src/ncs_queue.sv]
// ----------------------------------------------------------------------------
// ncs_queue
// Short register queue of run descriptors between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ncs_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire ncs_pkg::desc_t wr_data,
	output logic                full,
	input  wire logic           rd_en,
	output ncs_pkg::desc_t      rd_data,
	output logic                empty
);
	import ncs_pkg::*;

	desc_t           entry_q [QDEPTH];
	logic [PTRW-1:0] wr_ptr_q;
	logic [PTRW-1:0] rd_ptr_q;
	logic [CNTW-1:0] cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign full  = (cnt_q == CNTW'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PTRW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PTRW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

endmodule

`default_nettype wire

[src/ncs_back.sv]
// ----------------------------------------------------------------------------
// ncs_back
// Steps through the run of the head descriptor into an output register, one bus
// cycle per clock while that register is free or being popped.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nand_command_sequencer_top_assert.svh"

module ncs_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire ncs_pkg::desc_t q_desc,
	output logic                q_pop,
	output logic                empty,
	input  wire logic           pop,
	output logic [ncs_pkg::KINDW-1:0] cycle_kind,
	output logic [ncs_pkg::VALW-1:0]  cycle_value,
	output logic                last_cycle
);
	import ncs_pkg::*;

	logic [STEPW-1:0] step_q;
	logic             out_valid_q;
	bus_cycle_t       out_q;
	bus_cycle_t       next_cycle;
	logic             advance;

	assign next_cycle = cycle_at(q_desc, step_q);
	// load a new cycle when the output slot is free or being drained
	assign advance = !q_empty && (!out_valid_q || pop);
	assign q_pop   = advance && next_cycle.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				step_q      <= next_cycle.last ? '0 : step_q + STEPW'(1);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= next_cycle;
		end
	end

	assign empty       = !out_valid_q;
	assign cycle_kind  = out_q.kind;
	assign cycle_value = out_q.value;
	assign last_cycle  = out_q.last;

	`NCS_ASSERT_NEVER(a_step_range, clk, arst_n, step_q > MAX_STEP)
	`NCS_ASSERT(a_run_keeps_desc, clk, arst_n, (step_q != '0) |-> !q_empty)
	`NCS_ASSERT(a_last_rewinds, clk, arst_n, (advance && next_cycle.last) |=> (step_q == '0))
	`NCS_ASSERT(a_run_opens_cmd, clk, arst_n,
		(advance && (step_q == '0)) |=> (!empty && (cycle_kind == KIND_CMD)))

endmodule

`default_nettype wire

[src/nand_command_sequencer_top.sv]
// ----------------------------------------------------------------------------
// nand_command_sequencer_top
// NAND flash command/address sequencer: one request in, a run of bus cycles out.
// ----------------------------------------------------------------------------
// Each request is turned into its run of flash bus cycles, delivered one per
// clock while pop is held: a reset run has 1 bus cycle, read id and read status 2,
// page read 6 on small pages and 11 on large pages; the single output step
// counter sets this rate. Requests wait in a two-entry descriptor queue, so
// new ones are taken while a run is still being delivered. large_page is
// sampled when a request is accepted.
`default_nettype none

module nand_command_sequencer_top (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [ncs_pkg::OPW-1:0]  opcode,
	input  wire logic [ncs_pkg::COLW-1:0] column,
	input  wire logic [ncs_pkg::ROWW-1:0] page_row,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [ncs_pkg::KINDW-1:0]  cycle_kind,
	output logic [ncs_pkg::VALW-1:0]   cycle_value,
	output logic                       last_cycle,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_wdata
);
	import ncs_pkg::*;

	logic  q_push;
	logic  q_full;
	logic  q_empty;
	logic  q_pop;
	desc_t q_wr_desc;
	desc_t q_rd_desc;

	ncs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.opcode   (opcode),
		.column   (column),
		.page_row (page_row),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_desc   (q_wr_desc)
	);

	ncs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(q_wr_desc),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_data(q_rd_desc),
		.empty  (q_empty)
	);

	ncs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_desc     (q_rd_desc),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.cycle_kind (cycle_kind),
		.cycle_value(cycle_value),
		.last_cycle (last_cycle)
	);

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the NAND command sequencer: requests are pushed with
// random gaps, bus cycles are popped with random stalls, and every cycle is
// compared with a run predicted from the request and the page size setting.
// ----------------------------------------------------------------------------
import ncs_pkg::*;

class bus_cycle_board;
	bus_cycle_t cycles_due[$];
	bit large_page;
	int errors;
	int shown;

	function void set_large_page(bit v);
		large_page = v;
	endfunction

	function int outstanding();
		return cycles_due.size();
	endfunction

	function void add_cycle(logic [KINDW-1:0] kind, logic [VALW-1:0] value, bit last);
		bus_cycle_t c;
		c.kind  = kind;
		c.value = value;
		c.last  = last;
		cycles_due.push_back(c);
	endfunction

	// expected bus cycle run for one accepted request
	function void note_request(logic [OPW-1:0] op, logic [COLW-1:0] col,
			logic [ROWW-1:0] row);
		case (op)
			OP_RESET: begin
				add_cycle(KIND_CMD, CMD_RESET, 1'b1);
			end
			OP_READ_ID: begin
				add_cycle(KIND_CMD, CMD_READ_ID, 1'b0);
				add_cycle(KIND_ID_OUT, '0, 1'b1);
			end
			OP_STATUS: begin
				add_cycle(KIND_CMD, CMD_STATUS, 1'b0);
				add_cycle(KIND_STATUS_OUT, '0, 1'b1);
			end
			default: begin
				add_cycle(KIND_CMD, CMD_READ0, 1'b0);
				add_cycle(KIND_ADDR, col[7:0], 1'b0);
				if (large_page)
					add_cycle(KIND_ADDR, col[15:8], 1'b0);
				add_cycle(KIND_ADDR, row[7:0], 1'b0);
				add_cycle(KIND_ADDR, row[15:8], 1'b0);
				add_cycle(KIND_ADDR, row[23:16], 1'b0);
				if (large_page) begin
					add_cycle(KIND_CMD, CMD_READ_START, 1'b0);
					for (int b = 0; b < 4; b++)
						add_cycle(KIND_PAGE_OUT, VALW'(b), b == 3);
				end else begin
					add_cycle(KIND_PAGE_OUT, '0, 1'b1);
				end
			end
		endcase
	endfunction

	task report(string msg);
		errors++;
		if (shown < 40) begin
			shown++;
			$display("mismatch @%0t: %s", $time, msg);
		end
	endtask

	task check_cycle(logic [KINDW-1:0] kind, logic [VALW-1:0] value, logic last);
		bus_cycle_t want;
		if (cycles_due.size() == 0) begin
			report($sformatf("unexpected cycle kind %0d value %02h last %b",
				kind, value, last));
			return;
		end
		want = cycles_due.pop_front();
		if (kind !== want.kind)
			report($sformatf("cycle_kind %0d, want %0d", kind, want.kind));
		if (value !== want.value)
			report($sformatf("cycle_value %02h, want %02h", value, want.value));
		if (last !== want.last)
			report($sformatf("last_cycle %b, want %b", last, want.last));
	endtask
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 160;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic [OPW-1:0] opcode = '0;
	logic [COLW-1:0] column = '0;
	logic [ROWW-1:0] page_row = '0;
	logic full;
	logic empty;
	logic [KINDW-1:0] cycle_kind;
	logic [VALW-1:0] cycle_value;
	logic last_cycle;

	int send_idle = 13;
	int recv_idle = 75;
	int cycle_count = 0;
	bus_cycle_board sb = new();

	nand_command_sequencer_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.column      (column),
		.page_row    (page_row),
		.empty       (empty),
		.pop         (pop),
		.cycle_kind  (cycle_kind),
		.cycle_value (cycle_value),
		.last_cycle  (last_cycle),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	always @(negedge clk) begin
		pop <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && pop && empty === 1'b0)
			sb.check_cycle(cycle_kind, cycle_value, last_cycle);
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task send_request(logic [OPW-1:0] op, logic [COLW-1:0] col, logic [ROWW-1:0] row);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push     <= 1'b1;
		opcode   <= op;
		column   <= col;
		page_row <= row;
		@(posedge clk);
		while (full !== 1'b0) @(posedge clk);
		sb.note_request(op, col, row);
		@(negedge clk);
	endtask

	task drain();
		push <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task write_large_page(bit v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_large_page(v);
	endtask

	task run_phase(int s_idle, int r_idle);
		logic [OPW-1:0] op;
		logic [COLW-1:0] col;
		logic [ROWW-1:0] row;
		send_idle = s_idle;
		recv_idle = r_idle;
		repeat (PHASE_ITEMS) begin
			// page reads carry the longest runs, so favor them
			op = ($urandom_range(1) == 1) ? OP_READ_PAGE : OPW'($urandom_range(2));
			case ($urandom_range(7))
				0: col = '0;
				1: col = '1;
				default: col = COLW'($urandom);
			endcase
			case ($urandom_range(7))
				0: row = '0;
				1: row = '1;
				default: row = ROWW'($urandom);
			endcase
			send_request(op, col, row);
		end
		drain();
	endtask

	task directed_requests();
		send_request(OP_RESET, '0, '0);
		send_request(OP_RESET, '1, '1);
		send_request(OP_READ_ID, '0, '0);
		send_request(OP_READ_ID, 16'hA5C3, 24'h5A3C96);
		send_request(OP_STATUS, '0, '0);
		send_request(OP_STATUS, '1, '1);
		send_request(OP_READ_PAGE, '0, '0);
		send_request(OP_READ_PAGE, '1, '1);
		send_request(OP_READ_PAGE, 16'hFF00, 24'h00FF00);
		send_request(OP_READ_PAGE, 16'h00FF, 24'hFF00FF);
		send_request(OP_READ_PAGE, 16'h1234, 24'hABCDEF);
		drain();
	endtask

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// small pages: column high byte skipped, single read-out
		write_large_page(1'b0);
		directed_requests();
		write_large_page(1'b1);
		directed_requests();

		run_phase(13, 75);
		write_large_page(1'b0);
		run_phase(75, 13);
		write_large_page(1'b1);
		run_phase(0, 0);

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

[files.f]
+incdir+src
src/ncs_pkg.sv
src/ncs_front.sv
src/ncs_queue.sv
src/ncs_back.sv
src/nand_command_sequencer_top.sv
tb/tb.sv
